>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the button press classifier RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define BPC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked in the same cycle.
`define BPC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle.
`define BPC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define BPC_ASSERT(lbl, clk, rst, prop, msg)
`define BPC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define BPC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

>>> rtl/bpc_pkg.sv
// ---------------------------------------------------------------------------
// Button press classifier package
// Types and constants shared by the classifier, timer and top level modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

   localparam int TIMER_W = 23;

   localparam logic [3:0] SAMPLE_DIV_M1 = 4'd9;

   localparam logic [7:0] PRESS_SHORT_MIN = 8'd3;
   localparam logic [7:0] PRESS_LONG_AT   = 8'd25;
   localparam logic [7:0] PRESS_XLONG_AT  = 8'd250;

   localparam logic [4:0] EXT_SHORT_MIN = 5'd2;
   localparam logic [4:0] EXT_SHORT_END = 5'd10;
   localparam logic [4:0] EXT_LONG_AT   = 5'd20;
   localparam logic [4:0] EXT_SAT       = 5'd25;

   localparam logic [TIMER_W-1:0] TIMER_RESET        = 23'd10;
   localparam logic [TIMER_W-1:0] DISPLAY_TIMEOUT_RST  = 23'd300000;
   localparam logic [TIMER_W-1:0] POWEROFF_TIMEOUT_RST = 23'd1800000;

   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DISPLAY_TIMEOUT  = 2'd0,
      CSR_POWEROFF_TIMEOUT = 2'd1,
      CSR_EXTERNAL_ENABLE  = 2'd2
   } csr_index_type;

   // One input word, last field in the lowest bit.
   typedef struct packed {
      logic activity;
      logic display_on;
      logic key_level;
      logic start_down;
      logic button_down;
   } req_type;

   // One result word, last field in the lowest bit.
   typedef struct packed {
      logic poweroff_due;
      logic display_expired;
      logic start_long;
      logic ext_short;
      logic xlong_press;
      logic long_press;
      logic short_press;
   } rsp_type;

   // Classifier status handed to the rest of the block.
   typedef struct packed {
      logic timer_reload;
      logic start_long;
      logic ext_short;
      logic xlong_press;
      logic long_press;
      logic short_press;
   } class_type;

endpackage

`default_nettype wire

>>> rtl/bpc_press_classifier.sv
// ---------------------------------------------------------------------------
// Press classifier
// Sample divider plus button and external hold counters with press decode.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bpc_press_classifier (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic               ext_enable,
   input  wire bpc_pkg::req_type   req,
   output bpc_pkg::class_type      status
);
   import bpc_pkg::*;

   logic [3:0] phase_ff, phase_in;
   logic [7:0] press_count_ff, press_count_in;
   logic [4:0] ext_count_ff, ext_count_in;
   logic       sample;

   assign sample = (phase_ff == 4'd0);

   always_comb begin
      phase_in       = (phase_ff == SAMPLE_DIV_M1) ? 4'd0 : phase_ff + 4'd1;
      press_count_in = press_count_ff;
      ext_count_in   = ext_count_ff;
      status         = '0;

      if (sample) begin
         status.timer_reload = req.button_down | req.start_down;

         if (req.button_down) begin
            if (press_count_ff != PRESS_XLONG_AT) begin
               press_count_in = press_count_ff + 8'd1;
            end
            status.long_press  = (press_count_in == PRESS_LONG_AT);
            status.xlong_press = (press_count_in == PRESS_XLONG_AT) & req.display_on;
         end else begin
            status.short_press = (press_count_ff >= PRESS_SHORT_MIN) &&
                                 (press_count_ff < PRESS_LONG_AT);
            press_count_in = 8'd0;
         end

         if (!ext_enable) begin
            ext_count_in = 5'd0;
         end else if (req.start_down) begin
            if (ext_count_ff < EXT_SAT) begin
               ext_count_in = ext_count_ff + 5'd1;
            end
            status.start_long = (ext_count_in == EXT_LONG_AT) & req.key_level;
         end else begin
            status.ext_short = (ext_count_ff >= EXT_SHORT_MIN) &&
                               (ext_count_ff < EXT_SHORT_END);
            ext_count_in = 5'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= 4'd0;
         press_count_ff <= 8'd0;
         ext_count_ff   <= 5'd0;
      end else if (step) begin
         phase_ff       <= phase_in;
         press_count_ff <= press_count_in;
         ext_count_ff   <= ext_count_in;
      end
   end

   `BPC_ASSERT(a_phase_range, clock, reset, phase_ff <= SAMPLE_DIV_M1, "sample phase out of range")
   `BPC_ASSERT(a_press_sat, clock, reset, press_count_ff <= PRESS_XLONG_AT, "press count past saturation")
   `BPC_ASSERT(a_ext_sat, clock, reset, ext_count_ff <= EXT_SAT, "external count past saturation")
   `BPC_ASSERT_NXT(a_hold_between, clock, reset, step && !sample, $stable(press_count_ff) && $stable(ext_count_ff), "hold counters moved off a sample tick")
   `BPC_ASSERT_NXT(a_ext_disabled, clock, reset, step && sample && !ext_enable, ext_count_ff == 5'd0, "external count not cleared while disabled")

endmodule

`default_nettype wire

>>> rtl/bpc_timers.sv
// ---------------------------------------------------------------------------
// Inactivity timers
// Display-off and power-off countdowns with reload and expiry flags.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpc_timers (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire logic                          reload,
   input  wire logic [bpc_pkg::TIMER_W-1:0]   display_timeout,
   input  wire logic [bpc_pkg::TIMER_W-1:0]   poweroff_timeout,
   output logic                               display_expired,
   output logic                               poweroff_due
);
   import bpc_pkg::*;

   logic [TIMER_W-1:0] display_left_ff, display_left_in;
   logic [TIMER_W-1:0] poweroff_left_ff, poweroff_left_in;

   // The countdown comes first; a reload in the same tick wins over it.
   always_comb begin
      display_left_in  = (display_left_ff != '0) ? display_left_ff - TIMER_W'(1) : '0;
      poweroff_left_in = (poweroff_left_ff != '0) ? poweroff_left_ff - TIMER_W'(1) : '0;
      if (reload) begin
         display_left_in  = display_timeout;
         poweroff_left_in = poweroff_timeout;
      end
      display_expired = (display_timeout != '0) && (display_left_in == '0);
      poweroff_due    = (poweroff_timeout != '0) && (poweroff_left_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         display_left_ff  <= TIMER_RESET;
         poweroff_left_ff <= TIMER_RESET;
      end else if (step) begin
         display_left_ff  <= display_left_in;
         poweroff_left_ff <= poweroff_left_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/button_press_classifier_core.sv
// ---------------------------------------------------------------------------
// Button press classifier core
// Classifies front button and external start presses per 1 ms tick word and
// runs the display-off and power-off inactivity timers.
// ---------------------------------------------------------------------------
// Output: the result word for a tick is registered and appears in the cycle after it is accepted.
// Throughput: one tick word per cycle; the state update and decode fit between
// the accepting edge and the result register. Input stalls only while a result
// word waits and the result side is not ready.
// Reset: synchronous; the timers load 10, counters and sample phase clear, and
// the registers return to 300000, 1800000 and external enabled.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module button_press_classifier_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Tick input words.
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // [0] button_down, [1] start_down, [2] key_level, [3] display_on,
   // [4] activity, [7:5] zero
   input  wire logic [7:0]                       req_tdata,
   // Result words.
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [0] short_press, [1] long_press, [2] xlong_press, [3] ext_short,
   // [4] start_long, [5] display_expired, [6] poweroff_due, [7] zero
   output logic [7:0]                            rsp_tdata,
   // Register writes.
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [bpc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [bpc_pkg::TIMER_W-1:0]      csr_data
);
   import bpc_pkg::*;

   logic [TIMER_W-1:0] display_timeout_q_ff;
   logic [TIMER_W-1:0] poweroff_timeout_ff;
   logic               ext_enable_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff, rsp_in;
   req_type            req;
   class_type          status;
   logic               step;
   logic               timer_reload;
   logic               display_expired;
   logic               poweroff_due;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;
   assign req        = req_type'(req_tdata[4:0]);

   // Register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         display_timeout_q_ff <= DISPLAY_TIMEOUT_RST;
         poweroff_timeout_ff  <= POWEROFF_TIMEOUT_RST;
         ext_enable_ff        <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_DISPLAY_TIMEOUT:  display_timeout_q_ff <= csr_data;
            CSR_POWEROFF_TIMEOUT: poweroff_timeout_ff  <= csr_data;
            CSR_EXTERNAL_ENABLE:  ext_enable_ff        <= csr_data[0];
            default: ;
         endcase
      end
   end

   bpc_press_classifier u_classifier (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .ext_enable (ext_enable_ff),
      .req        (req),
      .status     (status)
   );

   assign timer_reload = status.timer_reload | req.activity;

   bpc_timers u_timers (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .reload           (timer_reload),
      .display_timeout  (display_timeout_q_ff),
      .poweroff_timeout (poweroff_timeout_ff),
      .display_expired  (display_expired),
      .poweroff_due     (poweroff_due)
   );

   always_comb begin
      rsp_in                 = '0;
      rsp_in.short_press     = status.short_press;
      rsp_in.long_press      = status.long_press;
      rsp_in.xlong_press     = status.xlong_press;
      rsp_in.ext_short       = status.ext_short;
      rsp_in.start_long      = status.start_long;
      rsp_in.display_expired = display_expired;
      rsp_in.poweroff_due    = poweroff_due;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff};

   `BPC_ASSERT_IMP(a_disp_flag_off, clock, reset, display_timeout_q_ff == '0, !display_expired, "display flag with zero timeout")

endmodule

`default_nettype wire
